/* hw/rtl/nhc_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// nhc_pkg
// Shared types and constants for the node health check block.
// ============================================================================
package nhc_pkg;

    localparam int NODE_COUNT = 16;
    localparam int IDX_W      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    localparam int TIME_W    = 48;
    localparam int ATTEMPT_W = 7;
    localparam int RETRY_W   = 7;
    localparam int DELAY_W   = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic [ATTEMPT_W-1:0] ATTEMPT_MAX = '1;
    localparam logic [TIME_W-1:0]    TIME_MAX    = '1;

    localparam logic [RETRY_W-1:0] MAX_RETRIES_RESET = 7'd2;
    localparam logic [DELAY_W-1:0] CONNECT_TIMEOUT_RESET = 31'd2000;
    localparam logic [DELAY_W-1:0] RETRY_DELAY_RESET = 31'd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_DELAY     = 2'd2;

    localparam logic REQ_NEW_ROUND = 1'b0;
    localparam logic REQ_STEP      = 1'b1;

    localparam logic [1:0] POLL_FAIL = 2'd0;
    localparam logic [1:0] POLL_OK   = 2'd1;

    typedef enum logic [2:0] {
        ST_INITIAL    = 3'd0,
        ST_CONNECTING = 3'd1,
        ST_OK         = 3'd2,
        ST_RETRY      = 3'd3,
        ST_DEAD       = 3'd4
    } check_state_t;

    typedef enum logic [1:0] {
        HL_UNKNOWN = 2'd0,
        HL_BAD     = 2'd1,
        HL_GOOD    = 2'd2
    } health_t;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_UNHEALTHY = 2'd1,
        EV_HEALTHY   = 2'd2
    } health_event_t;

    typedef enum logic [1:0] {
        C_IDLE   = 2'd0,
        C_CALC   = 2'd1,
        C_COMMIT = 2'd2,
        C_SEND   = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        logic              req_type;
        logic [3:0]        node_index;
        logic [TIME_W-1:0] now_ms;
        logic              start_ok;
        logic              socket_ready;
        logic [1:0]        poll_result;
    } in_word_t;

    typedef struct packed {
        logic [3:0]           node_index_out;
        logic [2:0]           check_state;
        logic [ATTEMPT_W-1:0] attempt_count;
        logic [1:0]           health_event;
        logic                 attempt_started;
        logic                 still_pending;
        logic [TIME_W-1:0]    deadline_out;
    } out_word_t;

    typedef struct packed {
        check_state_t         state;
        logic [ATTEMPT_W-1:0] attempts;
        logic [TIME_W-1:0]    deadline;
        health_t              health;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic calc;
        logic commit;
    } ctrl_cmd_t;

endpackage

/* hw/rtl/nhc_ctrl.sv */
`timescale 1ns / 1ps
// ============================================================================
// nhc_ctrl
// Sequencer that takes one word at a time through read, update and delivery.
// ============================================================================
module nhc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output nhc_pkg::ctrl_cmd_t cmd
);

    nhc_pkg::ctrl_state_t state_reg;
    nhc_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nhc_pkg::C_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        cmd         = '0;
        case (state_reg)
            nhc_pkg::C_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = nhc_pkg::C_CALC;
                end
            end
            nhc_pkg::C_CALC: begin
                cmd.calc   = 1'b1;
                state_next = nhc_pkg::C_COMMIT;
            end
            nhc_pkg::C_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = nhc_pkg::C_SEND;
            end
            nhc_pkg::C_SEND: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = nhc_pkg::C_IDLE;
                end
            end
            default: begin
                state_next = nhc_pkg::C_IDLE;
            end
        endcase
    end

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("Input accepted while a result is outstanding.");

    a_accept_to_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> cmd.calc)
        else $error("Accepted word did not move to the calculation step.");

    a_commit_to_send: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> (m_valid && !s_ready))
        else $error("Committed result was not presented.");

    a_single_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture, cmd.calc, cmd.commit}))
        else $error("More than one datapath command issued.");

endmodule

/* hw/rtl/nhc_datapath.sv */
`timescale 1ns / 1ps
// ============================================================================
// nhc_datapath
// Node entry table, deadline arithmetic, entry update and result register.
// ============================================================================
module nhc_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  nhc_pkg::ctrl_cmd_t                   cmd,
    input  nhc_pkg::in_word_t                    in_word,
    input  logic [nhc_pkg::RETRY_W-1:0]          max_retries,
    input  logic [nhc_pkg::DELAY_W-1:0]          connect_timeout_ms,
    input  logic [nhc_pkg::DELAY_W-1:0]          retry_delay_ms,
    output nhc_pkg::out_word_t                   out_word
);

    nhc_pkg::entry_t   table_reg [nhc_pkg::NODE_COUNT];
    nhc_pkg::in_word_t in_reg;
    nhc_pkg::entry_t   row_reg;
    logic [nhc_pkg::IDX_W-1:0]  idx;
    logic                       in_range;
    logic                       in_range_reg;
    logic [nhc_pkg::TIME_W:0]   sum_conn;
    logic [nhc_pkg::TIME_W:0]   sum_retry;
    logic [nhc_pkg::TIME_W-1:0] sum_conn_reg;
    logic [nhc_pkg::TIME_W-1:0] sum_retry_reg;
    logic                       dl_gt_now_reg;
    logic                       dl_lt_now_reg;
    logic                       exhausted_reg;
    nhc_pkg::entry_t            entry_next;
    nhc_pkg::health_event_t     event_next;
    logic                       started_next;
    logic                       launch;
    nhc_pkg::out_word_t         out_next;
    nhc_pkg::out_word_t         out_reg;

    assign idx      = nhc_pkg::IDX_W'(in_reg.node_index);
    assign in_range = 32'(in_reg.node_index) < nhc_pkg::NODE_COUNT;

    assign sum_conn  = {1'b0, in_reg.now_ms} + (nhc_pkg::TIME_W + 1)'(connect_timeout_ms);
    assign sum_retry = {1'b0, in_reg.now_ms} + (nhc_pkg::TIME_W + 1)'(retry_delay_ms);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= in_word;
        end
        if (cmd.calc) begin
            row_reg       <= table_reg[idx];
            in_range_reg  <= in_range;
            sum_conn_reg  <= sum_conn[nhc_pkg::TIME_W] ? nhc_pkg::TIME_MAX
                                                       : sum_conn[nhc_pkg::TIME_W-1:0];
            sum_retry_reg <= sum_retry[nhc_pkg::TIME_W] ? nhc_pkg::TIME_MAX
                                                        : sum_retry[nhc_pkg::TIME_W-1:0];
            dl_gt_now_reg <= table_reg[idx].deadline > in_reg.now_ms;
            dl_lt_now_reg <= table_reg[idx].deadline < in_reg.now_ms;
            exhausted_reg <= {1'b0, table_reg[idx].attempts}
                             >= ({1'b0, max_retries} + 8'd1);
        end
        if (cmd.commit) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < nhc_pkg::NODE_COUNT; i++) begin
                table_reg[i].state    <= nhc_pkg::ST_INITIAL;
                table_reg[i].attempts <= '0;
                table_reg[i].deadline <= '0;
                table_reg[i].health   <= nhc_pkg::HL_UNKNOWN;
            end
        end else if (cmd.commit && in_range_reg) begin
            table_reg[idx] <= entry_next;
        end
    end

    always_comb begin
        entry_next   = row_reg;
        event_next   = nhc_pkg::EV_NONE;
        started_next = 1'b0;
        launch       = 1'b0;
        if (in_reg.req_type == nhc_pkg::REQ_NEW_ROUND) begin
            entry_next.state    = nhc_pkg::ST_INITIAL;
            entry_next.attempts = '0;
            entry_next.deadline = '0;
        end else begin
            case (row_reg.state)
                nhc_pkg::ST_RETRY: begin
                    if (exhausted_reg) begin
                        if (row_reg.health != nhc_pkg::HL_BAD) begin
                            entry_next.health = nhc_pkg::HL_BAD;
                            event_next        = nhc_pkg::EV_UNHEALTHY;
                        end
                        entry_next.state = nhc_pkg::ST_DEAD;
                    end else if (!dl_gt_now_reg) begin
                        launch = 1'b1;
                    end
                end
                nhc_pkg::ST_INITIAL: begin
                    launch = 1'b1;
                end
                nhc_pkg::ST_CONNECTING: begin
                    if (dl_lt_now_reg) begin
                        entry_next.deadline = sum_retry_reg;
                        entry_next.state    = nhc_pkg::ST_RETRY;
                    end else if (in_reg.socket_ready) begin
                        if (in_reg.poll_result == nhc_pkg::POLL_FAIL) begin
                            entry_next.deadline = sum_retry_reg;
                            entry_next.state    = nhc_pkg::ST_RETRY;
                        end else if (in_reg.poll_result == nhc_pkg::POLL_OK) begin
                            if (row_reg.health != nhc_pkg::HL_GOOD) begin
                                entry_next.health = nhc_pkg::HL_GOOD;
                                event_next        = nhc_pkg::EV_HEALTHY;
                            end
                            entry_next.attempts = '0;
                            entry_next.state    = nhc_pkg::ST_OK;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (launch) begin
                if (in_reg.start_ok) begin
                    entry_next.deadline = sum_conn_reg;
                    entry_next.state    = nhc_pkg::ST_CONNECTING;
                end else begin
                    entry_next.deadline = sum_retry_reg;
                    entry_next.state    = nhc_pkg::ST_RETRY;
                end
                if (row_reg.attempts != nhc_pkg::ATTEMPT_MAX) begin
                    entry_next.attempts = row_reg.attempts + 1'b1;
                end
                started_next = 1'b1;
            end
        end
    end

    always_comb begin
        out_next                = '0;
        out_next.node_index_out = in_reg.node_index;
        if (in_range_reg) begin
            out_next.check_state     = entry_next.state;
            out_next.attempt_count   = entry_next.attempts;
            out_next.health_event    = event_next;
            out_next.attempt_started = started_next;
            out_next.still_pending   = (entry_next.state != nhc_pkg::ST_OK)
                                       && (entry_next.state != nhc_pkg::ST_DEAD);
            out_next.deadline_out    = entry_next.deadline;
        end
    end

    assign out_word = out_reg;

endmodule

/* hw/rtl/node_health_check_fsm.sv */
`timescale 1ns / 1ps
// ============================================================================
// node_health_check_fsm
// Table of per-node connection health checkers with one result per word.
// ============================================================================
// Each input word passes through these steps in order: accepting it, reading the
// node entry and forming the saturated deadline sums and compares, updating the
// entry and loading the result register, and handing the result over, which
// waits on m_ready. The sequencer holds one word at a time, so the next input
// word can be accepted in the cycle after the result word is taken. The node table
// resets all entries together, and configuration writes are always taken.
module node_health_check_fsm (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  nhc_pkg::in_word_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output nhc_pkg::out_word_t                m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [nhc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nhc_pkg::DELAY_W-1:0]       cfg_data
);

    logic [nhc_pkg::RETRY_W-1:0] max_retries_reg;
    logic [nhc_pkg::DELAY_W-1:0] connect_timeout_reg;
    logic [nhc_pkg::DELAY_W-1:0] retry_delay_reg;
    nhc_pkg::ctrl_cmd_t          cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_retries_reg     <= nhc_pkg::MAX_RETRIES_RESET;
            connect_timeout_reg <= nhc_pkg::CONNECT_TIMEOUT_RESET;
            retry_delay_reg     <= nhc_pkg::RETRY_DELAY_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                nhc_pkg::CFG_MAX_RETRIES: begin
                    max_retries_reg <= cfg_data[nhc_pkg::RETRY_W-1:0];
                end
                nhc_pkg::CFG_CONNECT_TIMEOUT: begin
                    connect_timeout_reg <= cfg_data;
                end
                nhc_pkg::CFG_RETRY_DELAY: begin
                    retry_delay_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    nhc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    nhc_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .in_word            (s_data),
        .max_retries        (max_retries_reg),
        .connect_timeout_ms (connect_timeout_reg),
        .retry_delay_ms     (retry_delay_reg),
        .out_word           (m_data)
    );

endmodule

/* tb/node_health_check_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// node_health_check_checker
// Watches the request, result and register channels of the node health
// table. For every accepted request word it works out the entry update and
// the result word, queues that prediction, and compares each result word,
// field by field, with the oldest prediction still waiting.
// ============================================================================
module node_health_check_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  nhc_pkg::in_word_t             s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  nhc_pkg::out_word_t            m_data,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [nhc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nhc_pkg::DELAY_W-1:0]   cfg_data,
    output int                            fail_count,
    output int                            pending_words,
    output int                            words_checked,
    output int                            unhealthy_events,
    output int                            healthy_events
);

    localparam int PRINT_LIMIT = 100;

    nhc_pkg::check_state_t         node_state    [nhc_pkg::NODE_COUNT];
    logic [nhc_pkg::ATTEMPT_W-1:0] node_attempts [nhc_pkg::NODE_COUNT];
    logic [nhc_pkg::TIME_W-1:0]    node_deadline [nhc_pkg::NODE_COUNT];
    nhc_pkg::health_t              node_health   [nhc_pkg::NODE_COUNT];

    logic [nhc_pkg::RETRY_W-1:0] retry_limit;
    logic [nhc_pkg::DELAY_W-1:0] conn_limit_ms;
    logic [nhc_pkg::DELAY_W-1:0] retry_delay;

    nhc_pkg::out_word_t expected_status [$];
    nhc_pkg::out_word_t predicted;
    nhc_pkg::out_word_t oldest;

    function automatic logic [nhc_pkg::TIME_W-1:0] deadline_after(
        input logic [nhc_pkg::TIME_W-1:0] base, input logic [nhc_pkg::DELAY_W-1:0] delay);
        logic [nhc_pkg::TIME_W:0] total;
        total = {1'b0, base} + (nhc_pkg::TIME_W + 1)'(delay);
        return total[nhc_pkg::TIME_W] ? nhc_pkg::TIME_MAX : total[nhc_pkg::TIME_W-1:0];
    endfunction

    task automatic report_mismatch(input string field, input logic [nhc_pkg::TIME_W-1:0] got,
                                   input logic [nhc_pkg::TIME_W-1:0] want);
        if (fail_count < PRINT_LIMIT) begin
            $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, field, got,
                     want);
        end
        fail_count++;
    endtask

    task automatic predict_status(input nhc_pkg::in_word_t request,
                                  output nhc_pkg::out_word_t status);
        int                     n;
        logic                   launch;
        logic                   started;
        nhc_pkg::health_event_t event_code;
        n = int'(request.node_index);
        launch = 1'b0;
        started = 1'b0;
        event_code = nhc_pkg::EV_NONE;
        if (request.req_type == nhc_pkg::REQ_NEW_ROUND) begin
            node_state[n] = nhc_pkg::ST_INITIAL;
            node_attempts[n] = '0;
            node_deadline[n] = '0;
        end else begin
            case (node_state[n])
                nhc_pkg::ST_RETRY: begin
                    if ({1'b0, node_attempts[n]} >= {1'b0, retry_limit} + 8'd1) begin
                        if (node_health[n] != nhc_pkg::HL_BAD) begin
                            node_health[n] = nhc_pkg::HL_BAD;
                            event_code = nhc_pkg::EV_UNHEALTHY;
                        end
                        node_state[n] = nhc_pkg::ST_DEAD;
                    end else if (node_deadline[n] <= request.now_ms) begin
                        launch = 1'b1;
                    end
                end
                nhc_pkg::ST_INITIAL: begin
                    launch = 1'b1;
                end
                nhc_pkg::ST_CONNECTING: begin
                    if (node_deadline[n] < request.now_ms ||
                        (request.socket_ready &&
                         request.poll_result == nhc_pkg::POLL_FAIL)) begin
                        node_deadline[n] = deadline_after(request.now_ms, retry_delay);
                        node_state[n] = nhc_pkg::ST_RETRY;
                    end else if (request.socket_ready &&
                                 request.poll_result == nhc_pkg::POLL_OK) begin
                        if (node_health[n] != nhc_pkg::HL_GOOD) begin
                            node_health[n] = nhc_pkg::HL_GOOD;
                            event_code = nhc_pkg::EV_HEALTHY;
                        end
                        node_attempts[n] = '0;
                        node_state[n] = nhc_pkg::ST_OK;
                    end
                end
                default: begin
                end
            endcase
            if (launch) begin
                if (request.start_ok) begin
                    node_deadline[n] = deadline_after(request.now_ms, conn_limit_ms);
                    node_state[n] = nhc_pkg::ST_CONNECTING;
                end else begin
                    node_deadline[n] = deadline_after(request.now_ms, retry_delay);
                    node_state[n] = nhc_pkg::ST_RETRY;
                end
                if (node_attempts[n] != nhc_pkg::ATTEMPT_MAX) begin
                    node_attempts[n] = node_attempts[n] + 1'b1;
                end
                started = 1'b1;
            end
        end
        status.node_index_out  = request.node_index;
        status.check_state     = node_state[n];
        status.attempt_count   = node_attempts[n];
        status.health_event    = event_code;
        status.attempt_started = started;
        status.still_pending   = (node_state[n] != nhc_pkg::ST_OK &&
                                  node_state[n] != nhc_pkg::ST_DEAD);
        status.deadline_out    = node_deadline[n];
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < nhc_pkg::NODE_COUNT; i++) begin
                node_state[i]    = nhc_pkg::ST_INITIAL;
                node_attempts[i] = '0;
                node_deadline[i] = '0;
                node_health[i]   = nhc_pkg::HL_UNKNOWN;
            end
            retry_limit      = nhc_pkg::MAX_RETRIES_RESET;
            conn_limit_ms    = nhc_pkg::CONNECT_TIMEOUT_RESET;
            retry_delay      = nhc_pkg::RETRY_DELAY_RESET;
            expected_status.delete();
            fail_count       = 0;
            words_checked    = 0;
            unhealthy_events = 0;
            healthy_events   = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    nhc_pkg::CFG_MAX_RETRIES:     retry_limit = cfg_data[nhc_pkg::RETRY_W-1:0];
                    nhc_pkg::CFG_CONNECT_TIMEOUT: conn_limit_ms = cfg_data;
                    nhc_pkg::CFG_RETRY_DELAY:     retry_delay = cfg_data;
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                predict_status(s_data, predicted);
                expected_status.push_back(predicted);
            end
            if (m_valid && m_ready) begin
                if (expected_status.size() == 0) begin
                    report_mismatch("word with no prediction",
                                    nhc_pkg::TIME_W'(m_data.node_index_out), '0);
                end else begin
                    oldest = expected_status.pop_front();
                    words_checked++;
                    if (oldest.health_event == nhc_pkg::EV_UNHEALTHY) unhealthy_events++;
                    if (oldest.health_event == nhc_pkg::EV_HEALTHY) healthy_events++;
                    if (m_data.node_index_out !== oldest.node_index_out)
                        report_mismatch("node_index_out",
                                        nhc_pkg::TIME_W'(m_data.node_index_out),
                                        nhc_pkg::TIME_W'(oldest.node_index_out));
                    if (m_data.check_state !== oldest.check_state)
                        report_mismatch("check_state", nhc_pkg::TIME_W'(m_data.check_state),
                                        nhc_pkg::TIME_W'(oldest.check_state));
                    if (m_data.attempt_count !== oldest.attempt_count)
                        report_mismatch("attempt_count",
                                        nhc_pkg::TIME_W'(m_data.attempt_count),
                                        nhc_pkg::TIME_W'(oldest.attempt_count));
                    if (m_data.health_event !== oldest.health_event)
                        report_mismatch("health_event",
                                        nhc_pkg::TIME_W'(m_data.health_event),
                                        nhc_pkg::TIME_W'(oldest.health_event));
                    if (m_data.attempt_started !== oldest.attempt_started)
                        report_mismatch("attempt_started",
                                        nhc_pkg::TIME_W'(m_data.attempt_started),
                                        nhc_pkg::TIME_W'(oldest.attempt_started));
                    if (m_data.still_pending !== oldest.still_pending)
                        report_mismatch("still_pending",
                                        nhc_pkg::TIME_W'(m_data.still_pending),
                                        nhc_pkg::TIME_W'(oldest.still_pending));
                    if (m_data.deadline_out !== oldest.deadline_out)
                        report_mismatch("deadline_out", m_data.deadline_out,
                                        oldest.deadline_out);
                end
            end
        end
        pending_words = expected_status.size();
    end

endmodule

/* tb/node_health_check_fsm_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// node_health_check_fsm_test
// Drives request words and register writes into the node health table and
// stalls the result side at random. A directed sequence walks one entry
// through every check state, then random sequences run under several
// register settings, from all-zero delays to saturating ones. The checker
// beside the block predicts and compares every result word.
// ============================================================================
module node_health_check_fsm_test;

    localparam int                            QUIET_LIMIT    = 1000;
    localparam logic [nhc_pkg::CFG_IDX_W-1:0] CFG_UNUSED     = 2'd3;
    localparam logic [1:0]                    POLL_PENDING   = 2'd2;
    localparam logic [1:0]                    POLL_UNDEFINED = 2'd3;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    nhc_pkg::in_word_t             s_data;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    nhc_pkg::out_word_t            m_data;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [nhc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [nhc_pkg::DELAY_W-1:0]   cfg_data;

    int fail_count;
    int pending_words;
    int words_checked;
    int unhealthy_events;
    int healthy_events;

    logic                       steady = 1'b0;
    int                         hold_left = 0;
    int                         quiet = 0;
    int                         requests_sent = 0;
    int                         settings_used = 1;
    logic [nhc_pkg::TIME_W-1:0] wall_ms;
    logic [nhc_pkg::TIME_W-1:0] steps_back;
    logic [63:0]                base_draw;
    logic [3:0]                 chain_node;

    node_health_check_fsm DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    node_health_check_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data           (s_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .fail_count       (fail_count),
        .pending_words    (pending_words),
        .words_checked    (words_checked),
        .unhealthy_events (unhealthy_events),
        .healthy_events   (healthy_events)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 93) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    always @(posedge aclk) begin
        if ($urandom_range(0, 299) == 0) steady <= !steady;
    end

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (!steady && $urandom_range(0, 99) < 30) begin
            hold_left <= pick_gap() - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles, %0d words outstanding", quiet,
                     pending_words);
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic nhc_pkg::in_word_t make_request(input logic req, input logic [3:0] node,
                                              input logic [nhc_pkg::TIME_W-1:0] now,
                                              input logic start_ok, input logic ready,
                                              input logic [1:0] poll);
        nhc_pkg::in_word_t w;
        w.req_type     = req;
        w.node_index   = node;
        w.now_ms       = now;
        w.start_ok     = start_ok;
        w.socket_ready = ready;
        w.poll_result  = poll;
        return w;
    endfunction

    task automatic post_request(input nhc_pkg::in_word_t w);
        int gap;
        gap = (!steady && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_words != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [nhc_pkg::CFG_IDX_W-1:0] index,
                             input logic [nhc_pkg::DELAY_W-1:0] value);
        cfg_index <= index;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic configure(input logic [nhc_pkg::DELAY_W-1:0] retries,
                             input logic [nhc_pkg::DELAY_W-1:0] timeout,
                             input logic [nhc_pkg::DELAY_W-1:0] delay);
        wait_idle();
        write_reg(nhc_pkg::CFG_MAX_RETRIES, retries);
        write_reg(nhc_pkg::CFG_CONNECT_TIMEOUT, timeout);
        write_reg(nhc_pkg::CFG_RETRY_DELAY, delay);
        write_reg(CFG_UNUSED, nhc_pkg::DELAY_W'($urandom));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input int count, input logic [3:0] first_node,
                             input int node_span, input int round_pct, input int start_pct,
                             input int unsigned max_advance, input int noise_pct);
        logic [nhc_pkg::TIME_W-1:0] stamp;
        logic [nhc_pkg::TIME_W:0]   later;
        logic [63:0]                noise;
        logic [3:0]                 node;
        logic                       req;
        for (int k = 0; k < count; k++) begin
            later = {1'b0, wall_ms} +
                    (nhc_pkg::TIME_W + 1)'($urandom_range(0, max_advance));
            wall_ms = later[nhc_pkg::TIME_W] ? nhc_pkg::TIME_MAX
                                             : later[nhc_pkg::TIME_W-1:0];
            noise = {$urandom, $urandom};
            stamp = ($urandom_range(0, 99) < noise_pct) ? noise[nhc_pkg::TIME_W-1:0]
                                                        : wall_ms;
            node = first_node + 4'($urandom_range(0, node_span - 1));
            req = ($urandom_range(0, 99) < round_pct) ? nhc_pkg::REQ_NEW_ROUND
                                                      : nhc_pkg::REQ_STEP;
            post_request(make_request(req, node, stamp, $urandom_range(0, 99) < start_pct,
                                      1'($urandom_range(0, 1)),
                                      2'($urandom_range(0, 3))));
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= nhc_pkg::CFG_MAX_RETRIES;
        cfg_data  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // One entry walks through connect, timeout, retry, failed start and death
        // under the reset settings, then through a fresh round to a healthy node.
        post_request(make_request(nhc_pkg::REQ_STEP, 4'd0, 48'd0, 1'b1, 1'b0,
                                  nhc_pkg::POLL_FAIL));
        post_request(make_request(nhc_pkg::REQ_STEP, 4'd0, 48'd2000, 1'b0, 1'b1,
                                  POLL_PENDING));
        post_request(make_request(nhc_pkg::REQ_STEP, 4'd0, 48'd2000, 1'b0, 1'b1,
                                  POLL_UNDEFINED));
        post_request(make_request(nhc_pkg::REQ_STEP, 4'd0, 48'd2001, 1'b1, 1'b1,
                                  nhc_pkg::POLL_OK));
        post_request(make_request(nhc_pkg::REQ_STEP, 4'd0, 48'd3000, 1'b1, 1'b0,
                                  nhc_pkg::POLL_FAIL));
        post_request(make_request(nhc_pkg::REQ_STEP, 4'd0, 48'd3001, 1'b0, 1'b0,
                                  nhc_pkg::POLL_FAIL));
        post_request(make_request(nhc_pkg::REQ_STEP, 4'd0, 48'd4001, 1'b1, 1'b0,
                                  nhc_pkg::POLL_FAIL));
        post_request(make_request(nhc_pkg::REQ_STEP, 4'd0, 48'd4500, 1'b1, 1'b1,
                                  nhc_pkg::POLL_FAIL));
        post_request(make_request(nhc_pkg::REQ_STEP, 4'd0, 48'd5500, 1'b1, 1'b0,
                                  nhc_pkg::POLL_FAIL));
        post_request(make_request(nhc_pkg::REQ_STEP, 4'd0, 48'd9000, 1'b1, 1'b1,
                                  nhc_pkg::POLL_OK));
        post_request(make_request(nhc_pkg::REQ_NEW_ROUND, 4'd0, nhc_pkg::TIME_MAX, 1'b1, 1'b1,
                                  POLL_UNDEFINED));
        post_request(make_request(nhc_pkg::REQ_STEP, 4'd0, 48'd10000, 1'b1, 1'b0,
                                  nhc_pkg::POLL_FAIL));
        post_request(make_request(nhc_pkg::REQ_STEP, 4'd0, 48'd10001, 1'b0, 1'b1,
                                  nhc_pkg::POLL_OK));
        post_request(make_request(nhc_pkg::REQ_STEP, 4'd0, 48'd12000, 1'b1, 1'b1,
                                  nhc_pkg::POLL_FAIL));
        post_request(make_request(nhc_pkg::REQ_NEW_ROUND, 4'd0, 48'd0, 1'b0, 1'b0,
                                  nhc_pkg::POLL_FAIL));
        post_request(make_request(nhc_pkg::REQ_STEP, 4'd0, 48'd20000, 1'b1, 1'b0,
                                  nhc_pkg::POLL_FAIL));
        post_request(make_request(nhc_pkg::REQ_STEP, 4'd0, 48'd20001, 1'b1, 1'b0,
                                  nhc_pkg::POLL_OK));
        post_request(make_request(nhc_pkg::REQ_STEP, 4'd0, 48'd22000, 1'b1, 1'b1,
                                  nhc_pkg::POLL_OK));
        post_request(make_request(nhc_pkg::REQ_STEP, 4'd15, nhc_pkg::TIME_MAX, 1'b1, 1'b0,
                                  nhc_pkg::POLL_FAIL));
        post_request(make_request(nhc_pkg::REQ_STEP, 4'd15, nhc_pkg::TIME_MAX, 1'b1, 1'b1,
                                  nhc_pkg::POLL_FAIL));
        post_request(make_request(nhc_pkg::REQ_STEP, 4'd15, nhc_pkg::TIME_MAX, 1'b1, 1'b0,
                                  POLL_PENDING));

        configure(31'd2, 31'd20, 31'd10);
        base_draw = {$urandom, $urandom};
        wall_ms = {4'h0, base_draw[nhc_pkg::TIME_W-5:0]};
        run_phase(130, 4'($urandom_range(0, 15)), 4, 8, 75, 8, 4);

        configure(31'd0, 31'd0, 31'd0);
        run_phase(90, 4'd0, 16, 10, 60, 2, 3);

        // Upper data bits are dropped, so the retry limit becomes the largest
        // value and one entry keeps failing until its attempt count saturates.
        configure(31'h7FFF_FFFF, 31'd1, 31'd1);
        chain_node = 4'($urandom_range(0, 15));
        post_request(make_request(nhc_pkg::REQ_NEW_ROUND, chain_node, wall_ms, 1'b0, 1'b0,
                                  nhc_pkg::POLL_FAIL));
        run_phase(220, chain_node, 1, 0, 0, 3, 0);

        configure(nhc_pkg::DELAY_W'($urandom_range(1, 6)),
                  nhc_pkg::DELAY_W'($urandom_range(1, 40)),
                  nhc_pkg::DELAY_W'($urandom_range(1, 40)));
        run_phase(100, 4'd0, 16, 8, 70, 12, 3);

        configure(31'd100, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        steps_back = nhc_pkg::TIME_W'($urandom_range(40, 80));
        wall_ms = nhc_pkg::TIME_MAX - (steps_back << 31);
        run_phase(80, 4'($urandom_range(0, 15)), 3, 8, 70, 32'h7FFF_FFFF, 3);

        wait_idle();
        $display("Run covered %0d request words under %0d register settings.", requests_sent,
                 settings_used);
        $display("Result words checked: %0d, with %0d unhealthy and %0d healthy events.",
                 words_checked, unhealthy_events, healthy_events);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
